[rtl/aes_pkg.sv]
// AES-128 package: S-box, GF(2^8) helpers, round and key-schedule functions.
// No dependencies; used by every module of the aes128_block_encrypt block.
`timescale 1ns / 1ps

package aes_pkg;

  localparam int unsigned NumRounds = 10;

  // config register indexes
  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;

  // round key pipeline carries key state alongside data
  typedef logic [127:0] blk_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
      8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
      8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
      8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
      8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
      8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
      8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
      8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
      8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
      8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
      8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
      8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
      8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
      8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
      8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
      8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
      8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
      8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
      8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
      8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
      8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
      8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
      8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
      8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
      8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
      8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
      8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
      8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
      8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
      8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
      8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
      8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
      8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
      8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
      8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
      8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
      8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
      8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
      8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
      8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
      8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
      8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
      8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
      8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
      8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
      8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
      8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
      8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
      8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
      8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
      8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
      8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
      8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // multiply by x, reduction polynomial 0x1B
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // byte i of a block; byte 0 sits in bits 127:120
  function automatic logic [7:0] get_byte(input blk_t s, input int unsigned i);
    return s[127 - 8*i -: 8];
  endfunction

  // one cipher round; mix = 0 on the final round
  function automatic blk_t enc_round(input blk_t s, input blk_t rk, input logic mix);
    blk_t t;
    blk_t m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(t, 4*c);
      a1 = get_byte(t, 4*c + 1);
      a2 = get_byte(t, 4*c + 2);
      a3 = get_byte(t, 4*c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      m[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return (mix ? m : t) ^ rk;
  endfunction

  // next round key from the current one
  function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rcon(input int unsigned n);
    logic [7:0] rc;
    rc = 8'h01;
    for (int i = 1; i < 10; i++) begin
      if (i < n) rc = xtime(rc);
    end
    return rc;
  endfunction

endpackage

[rtl/aes128_block_encrypt.sv]
// AES-128 encryption, one 16-byte block per word at full rate. There is
// one register stage for the initial key add, then one register stage per
// round (ten), each also deriving its round key, so the key travels with the
// block. Throughput is one word per cycle; the whole pipe advances whenever
// the last stage is empty or its word is taken, so a stall holds every stage
// and loses nothing. The key (cfg index 0 = bytes 0..7, 1 = bytes 8..15,
// byte 0 most significant) is sampled when a word is accepted; write it only
// while the pipe is empty. The high half (bytes 0..7) sits in tdata[63:0],
// so data byte 0 sits in tdata[63:56] and byte 8 in tdata[127:120].
// Depends on aes_pkg and aes_round.
`timescale 1ns / 1ps

module aes128_block_encrypt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // block_high [63:0], block_low [127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // cipher_high [63:0], cipher_low [127:64]
);

  localparam int unsigned NR = aes_pkg::NumRounds;

  logic [63:0]   key_high_r;
  logic [63:0]   key_low_r;
  logic          en;
  logic          vld [NR+1];
  aes_pkg::blk_t st  [NR+1];
  aes_pkg::blk_t key [NR+1];
  logic          v0_r;
  aes_pkg::blk_t s0_r;
  aes_pkg::blk_t k0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        aes_pkg::CfgKeyHigh: key_high_r <= cfg_wdata;
        aes_pkg::CfgKeyLow:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: last stage empty or draining
  assign en        = !vld[NR] || out_tready;
  assign in_tready = en;

  // stage 0: whitening with the cipher key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
    if (en) begin
      s0_r <= {in_tdata[63:0], in_tdata[127:64]} ^ {key_high_r, key_low_r};
      k0_r <= {key_high_r, key_low_r};
    end
  end

  assign vld[0] = v0_r;
  assign st[0]  = s0_r;
  assign key[0] = k0_r;

  for (genvar g = 1; g <= NR; g++) begin : g_rnd
    aes_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .rc      (aes_pkg::rcon(g)),
      .last    (g == NR),
      .vld_in  (vld[g-1]),
      .st_in   (st[g-1]),
      .key_in  (key[g-1]),
      .vld_out (vld[g]),
      .st_out  (st[g]),
      .key_out (key[g])
    );
  end

  assign out_tvalid = vld[NR];
  assign out_tdata  = {st[NR][63:0], st[NR][127:64]};

`ifndef SYNTHESIS
  // a held result must not change under stall
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed during stall");
  // input side is ready whenever the output side can drain
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("pipe stalled with ready output");
`endif

endmodule

[rtl/aes_round.sv]
// One pipelined AES round stage: data round plus on-the-fly key expansion.
// Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_round (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [7:0]    rc,       // round constant for this stage
  input  logic          last,     // final round: no MixColumns
  input  logic          vld_in,
  input  aes_pkg::blk_t st_in,
  input  aes_pkg::blk_t key_in,
  output logic          vld_out,
  output aes_pkg::blk_t st_out,
  output aes_pkg::blk_t key_out
);

  aes_pkg::blk_t key_nxt;
  aes_pkg::blk_t st_nxt;
  logic          vld_r;
  aes_pkg::blk_t st_r;
  aes_pkg::blk_t key_r;

  assign key_nxt = aes_pkg::next_key(key_in, rc);
  assign st_nxt  = aes_pkg::enc_round(st_in, key_nxt, !last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      st_r  <= st_nxt;
      key_r <= key_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign key_out = key_r;

endmodule

[tb/sv/aes128_block_encrypt_tb.sv]
// Testbench for aes128_block_encrypt: directed and random AES-128 blocks checked
// against an in-bench cipher predictor, with random sender bursts and receiver stalls.
// Depends on aes_pkg (register indexes) and the aes128_block_encrypt RTL.
`timescale 1ns / 1ps

module aes128_block_encrypt_tb;

  localparam int PipeDepth = 11;
  localparam int CycleLimit = 400000;

  // cipher predictor and the queue of expected ciphertext words
  class cipher_scoreboard;
    logic [127:0] key;
    logic [127:0] cipher_q[$];
    int errors;
    int checked;
    byte unsigned sbox_t[256];

    function new();
      byte unsigned p, q, x;
      key = '0;
      errors = 0;
      checked = 0;
      // build the S-box from its definition: inverse in GF(2^8) plus affine map
      p = 1;
      q = 1;
      do begin
        p = p ^ (p << 1) ^ ((p & 8'h80) ? 8'h1B : 8'h00);
        q ^= q << 1;
        q ^= q << 2;
        q ^= q << 4;
        if (q & 8'h80) q ^= 8'h09;
        x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
        sbox_t[p] = x ^ 8'h63;
      end while (p != 1);
      sbox_t[0] = 8'h63;
    endfunction

    function byte unsigned dbl(byte unsigned b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function logic [127:0] encrypt(logic [127:0] blk);
      byte unsigned rk[176];
      byte unsigned st[16];
      byte unsigned tmp[16];
      byte unsigned tw[4];
      byte unsigned first, rc, a0, a1, a2, a3, al;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
        rk[i] = key[127 - 8*i -: 8];
        st[i] = blk[127 - 8*i -: 8];
      end
      rc = 1;
      for (int i = 4; i < 44; i++) begin
        for (int k = 0; k < 4; k++) tw[k] = rk[4*(i-1) + k];
        if (i % 4 == 0) begin
          first = tw[0];
          tw[0] = sbox_t[tw[1]] ^ rc;
          tw[1] = sbox_t[tw[2]];
          tw[2] = sbox_t[tw[3]];
          tw[3] = sbox_t[first];
          rc = dbl(rc);
        end
        for (int k = 0; k < 4; k++) rk[4*i + k] = rk[4*(i-4) + k] ^ tw[k];
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      for (int n = 1; n <= 10; n++) begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) tmp[r + 4*c] = sbox_t[st[r + 4*((c + r) % 4)]];
        st = tmp;
        if (n < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[16*n + i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
      return res;
    endfunction

    function void note_block(logic [127:0] blk);
      cipher_q.push_back(encrypt(blk));
    endfunction

    function void check_cipher(logic [127:0] got);
      logic [127:0] exp;
      if (cipher_q.size() == 0) begin
        $error("unexpected cipher word %h", got);
        errors++;
        return;
      end
      exp = cipher_q.pop_front();
      checked++;
      if (got[127:64] !== exp[127:64]) begin
        $error("cipher_high: expected %h, got %h", exp[127:64], got[127:64]);
        errors++;
      end
      if (got[63:0] !== exp[63:0]) begin
        $error("cipher_low: expected %h, got %h", exp[63:0], got[63:0]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [63:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  cipher_scoreboard sb;
  int cycles = 0;
  int stall_mode = 0;
  int blocks_sent = 0;
  int keys_used = 0;

  always #10 clk = ~clk;

  aes128_block_encrypt DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: checks taken words and draws its stall pattern at random
  // the word carries cipher_high in its low half
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_cipher({out_tdata[63:0], out_tdata[127:64]});
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;                          // no stalls
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= (cycles % 7 < 3);        // periodic long stalls
    endcase
  end

  // key write only while the pipe is empty; cfg_we drops again before the task returns
  task automatic write_reg(logic idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == aes_pkg::CfgKeyHigh) sb.key[127:64] = val;
    else sb.key[63:0] = val;
    @(posedge clk);
  endtask

  task automatic load_key(logic [127:0] k);
    write_reg(aes_pkg::CfgKeyHigh, k[127:64]);
    write_reg(aes_pkg::CfgKeyLow, k[63:0]);
    keys_used++;
  endtask

  // present one word; valid stays high across back-to-back words when keep is set
  task automatic send_block(logic [127:0] blk, bit keep);
    in_tvalid <= 1'b1;
    in_tdata <= {blk[63:0], blk[127:64]};
    do @(posedge clk); while (!in_tready);
    sb.note_block(blk);
    blocks_sent++;
    if (!keep) in_tvalid <= 1'b0;
  endtask

  // random bursts with random gaps
  task automatic send_bursts(int count, bit structured);
    int burst, gap;
    logic [127:0] blk;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > count) burst = count;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        blk = {$urandom, $urandom, $urandom, $urandom};
        if (structured && $urandom_range(0, 7) == 0)
          blk = $urandom_range(0, 1) ? {128{1'b1}} << $urandom_range(0, 127) :
                ~(128'h1 << $urandom_range(0, 127));
        // a zero gap joins the next burst without dropping valid
        send_block(blk, (i != burst - 1) || (gap == 0 && count > burst));
      end
      count -= burst;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (sb.cipher_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key (all zero) with extreme blocks
    send_block(128'h0, 1'b1);
    send_block({128{1'b1}}, 1'b0);
    drain();
    // standard FIPS-197 vector
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    send_block(128'h00112233445566778899aabbccddeeff, 1'b1);
    send_block(128'h3243f6a8885a308d313198a2e0370734, 1'b1);
    send_block(128'h0, 1'b1);
    send_block({128{1'b1}}, 1'b0);
    drain();
    load_key({128{1'b1}});
    for (int i = 0; i < 8; i++) send_block(128'h1 << (i * 17), 1'b1);
    send_block({64'h0, {64{1'b1}}}, 1'b1);
    send_block({{64{1'b1}}, 64'h0}, 1'b0);
    drain();
    // only one half rewritten: the other half keeps its value
    write_reg(aes_pkg::CfgKeyLow, 64'h0);
    send_block(128'h2b7e151628aed2a6abf7158809cf4f3c, 1'b0);
    drain();
    write_reg(aes_pkg::CfgKeyHigh, 64'h0);
    send_block(128'h8000_0000_0000_0000_0000_0000_0000_0001, 1'b0);
    drain();

    // random phases, each with a fresh key, some extreme
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_key(128'h0);
        1: load_key({128{1'b1}});
        default: load_key({$urandom, $urandom, $urandom, $urandom});
      endcase
      send_bursts(110, 1'b1);
      drain();
    end

    $display("encrypted %0d blocks under %0d keys, %0d cipher words checked",
             blocks_sent, keys_used, sb.checked);
    if (sb.errors == 0 && sb.cipher_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
